### sv/cdt_pkg.sv
// shared types, command codes and display constants for the countdown timer
package cdt_pkg;

  localparam logic [1:0] MODE_TICK  = 2'd0;
  localparam logic [1:0] MODE_START = 2'd1;
  localparam logic [1:0] MODE_PAUSE = 2'd2;
  localparam logic [1:0] MODE_STOP  = 2'd3;

  localparam logic [7:0]  DP_BIT   = 8'h80;
  localparam logic [15:0] HUNDRED  = 16'd100;
  localparam logic [15:0] THOUSAND = 16'd1000;
  localparam logic [7:0]  BLANK    = 8'h00;

  typedef struct packed {
    logic [1:0] mode;
    logic [9:0] seconds;
    logic       paused;
  } cmd_t;

  typedef struct packed {
    logic [7:0]  segments;
    logic        digit_select;
    logic        expired;
    logic [15:0] remaining;
  } disp_t;

  // seven-segment font, bit 0 is segment a
  function automatic logic [7:0] seg_font(input logic [3:0] digit);
    logic [7:0] pat;
    case (digit)
      4'd0: pat = 8'd63;
      4'd1: pat = 8'd6;
      4'd2: pat = 8'd91;
      4'd3: pat = 8'd79;
      4'd4: pat = 8'd102;
      4'd5: pat = 8'd109;
      4'd6: pat = 8'd125;
      4'd7: pat = 8'd7;
      4'd8: pat = 8'd127;
      4'd9: pat = 8'd111;
      default: pat = 8'd0;
    endcase
    return pat;
  endfunction

endpackage

### sv/cdt_display.sv
// digit extraction and segment pattern for one multiplexed display digit
module cdt_display import cdt_pkg::*; (
  input  logic [15:0] count,
  input  logic        sel,
  output logic [7:0]  pattern
);

  // reciprocal multiplies, exact over the full 16-bit range
  logic [32:0] prod100;
  logic [32:0] prod1000;
  logic [32:0] prod10000;
  logic [14:0] prod10;
  logic [9:0]  q100;
  logic [6:0]  q1000;
  logic [2:0]  q10000;
  logic [3:0]  tens_digit;
  logic [9:0]  hund_rem;
  logic [6:0]  thou_rem;

  assign prod100   = 33'(count) * 33'd83887;
  assign prod1000  = 33'(count) * 33'd67109;
  assign prod10000 = 33'(count) * 33'd107375;
  assign prod10    = 15'(count[6:0]) * 15'd205;

  assign q100   = prod100[32:23];
  assign q1000  = prod1000[32:26];
  assign q10000 = prod10000[32:30];

  // only used below one hundred, so the low seven bits suffice
  assign tens_digit = prod10[14:11];
  assign hund_rem   = q100 - 10'(q1000) * 10'd10;
  assign thou_rem   = q1000 - 7'(q10000) * 7'd10;

  always_comb begin
    if (sel) begin
      if (count < HUNDRED) pattern = seg_font(tens_digit);
      else                 pattern = seg_font(hund_rem[3:0]);
    end else begin
      if (count < HUNDRED)       pattern = seg_font(4'd0) | DP_BIT;
      else if (count < THOUSAND) pattern = BLANK;
      else                       pattern = seg_font(thou_rem[3:0]);
    end
  end

endmodule

### sv/cdt_ctrl.sv
// timer state registers and command decode
module cdt_ctrl import cdt_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  fire,
  input  cmd_t  cmd,
  output disp_t result
);

  logic [15:0] count, count_next;
  logic        running, running_next;
  logic        expired_flag, expired_flag_next;
  logic        select_bit, select_bit_next;
  logic [7:0]  segment_reg, segment_reg_next;

  logic [15:0] tick_count;
  logic [15:0] start_count;
  logic [17:0] start_prod;
  logic [7:0]  tick_pattern;

  assign tick_count  = running ? count - 16'd1 : count;
  assign start_prod  = 18'({1'b0, cmd.seconds} + 11'd1) * 18'd100;
  assign start_count = start_prod[15:0];

  cdt_display u_display (
    .count   (tick_count),
    .sel     (select_bit),
    .pattern (tick_pattern)
  );

  always_comb begin
    count_next        = count;
    running_next      = running;
    expired_flag_next = expired_flag;
    select_bit_next   = select_bit;
    segment_reg_next  = segment_reg;
    case (cmd.mode)
      MODE_TICK: begin
        count_next = tick_count;
        if (running && tick_count == 16'd0) begin
          running_next      = 1'b0;
          expired_flag_next = 1'b1;
        end
        segment_reg_next = tick_pattern;
        select_bit_next  = ~select_bit;
      end
      MODE_START: begin
        count_next        = start_count;
        running_next      = 1'b1;
        expired_flag_next = 1'b0;
      end
      MODE_PAUSE: begin
        running_next = ~cmd.paused;
      end
      default: begin
        count_next        = 16'd0;
        running_next      = 1'b0;
        expired_flag_next = 1'b1;
      end
    endcase
  end

  always_comb begin
    result.segments     = segment_reg_next;
    result.digit_select = select_bit_next;
    result.expired      = expired_flag_next;
    result.remaining    = count_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count        <= 16'd0;
      running      <= 1'b0;
      expired_flag <= 1'b0;
      select_bit   <= 1'b0;
      segment_reg  <= 8'd0;
    end else if (fire) begin
      count        <= count_next;
      running      <= running_next;
      expired_flag <= expired_flag_next;
      select_bit   <= select_bit_next;
      segment_reg  <= segment_reg_next;
    end
  end

endmodule

### sv/countdown_timer_seven_seg.sv
// top level of the centisecond countdown timer with two-digit display
//
//   channel  direction  handshake              payload
//   cmd      in         cmd_valid / cmd_stall    cmd_t  (mode, seconds, paused)
//   disp     out        disp_valid / disp_stall  disp_t (segments, digit_select,
//                                                        expired, remaining)
//
// one transaction per cycle sustained while disp is not stalled; a taken command
// passes through the command register, then the result register
// the only long path is the tick decrement feeding the constant-reciprocal
// digit extraction in the display unit, between the two registers
// rst is synchronous: count, flags, select bit and segment latch clear to zero
// a stall on disp holds the result; cmd keeps being taken while the command
// register can drain into the result register
module countdown_timer_seven_seg import cdt_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  cmd_valid,
  output logic  cmd_stall,
  input  cmd_t  cmd,
  output logic  disp_valid,
  input  logic  disp_stall,
  output disp_t disp
);

  // command register
  logic  held_valid;
  cmd_t  held_cmd;

  // the held command moves on when the result register is free or draining
  logic  advance;
  disp_t result;

  assign advance   = held_valid && (!disp_valid || !disp_stall);
  assign cmd_stall = held_valid && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (!cmd_stall) begin
      held_valid <= cmd_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_valid && !cmd_stall) begin
      held_cmd <= cmd;
    end
  end

  // state update happens as the command leaves the command register
  cdt_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .fire   (advance),
    .cmd    (held_cmd),
    .result (result)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      disp_valid <= 1'b0;
    end else if (advance) begin
      disp_valid <= 1'b1;
    end else if (!disp_stall) begin
      disp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      disp <= result;
    end
  end

`ifndef SYNTHESIS
  // backpressure on cmd only while a command is parked
  a_stall_needs_held: assert property (@(posedge clk) disp_valid === 1'b1 && rst == 1'b0
    && cmd_stall |-> held_valid)
    else $error("cmd stalled with empty command register");

  // a parked command is neither lost nor altered
  a_held_keeps: assert property (@(posedge clk) disable iff (rst)
    held_valid && !advance |=> held_valid && $stable(held_cmd))
    else $error("parked command lost or changed");

  // every command that moves on lands in the result register
  a_advance_lands: assert property (@(posedge clk) disable iff (rst)
    advance |=> disp_valid)
    else $error("advanced command produced no result");
`endif

endmodule

### test/tb.sv
// self-checking testbench for the countdown timer with scoreboard and random command streams
`timescale 1ns / 1ps

import cdt_pkg::*;

class timer_scoreboard;
  logic [15:0] count_cs;
  logic        running;
  logic        expired;
  logic        sel;
  logic [7:0]  seg_latch;
  disp_t       pending_displays[$];
  int          errors;

  function new();
    count_cs  = '0;
    running   = 1'b0;
    expired   = 1'b0;
    sel       = 1'b0;
    seg_latch = '0;
    errors    = 0;
  endfunction

  // pattern for one display digit, select bit as it stood before the tick
  function logic [7:0] digit_pattern(logic [15:0] c, logic s);
    logic [79:0] glyphs;
    int          d;
    glyphs = {8'd111, 8'd127, 8'd7, 8'd125, 8'd109, 8'd102, 8'd79, 8'd91, 8'd6, 8'd63};
    if (s) begin
      d = (c < HUNDRED) ? int'((c / 10) % 10) : int'((c / 100) % 10);
      return glyphs[d*8 +: 8];
    end
    if (c < HUNDRED) return glyphs[7:0] | DP_BIT;
    if (c < THOUSAND) return BLANK;
    d = int'((c / 1000) % 10);
    return glyphs[d*8 +: 8];
  endfunction

  function disp_t predict_display(cmd_t c);
    logic [31:0] load;
    disp_t       r;
    case (c.mode)
      MODE_TICK: begin
        if (running) begin
          count_cs = count_cs - 16'd1;
          if (count_cs == 16'd0) begin
            running = 1'b0;
            expired = 1'b1;
          end
        end
        seg_latch = digit_pattern(count_cs, sel);
        sel = ~sel;
      end
      MODE_START: begin
        // out-of-range seconds wrap modulo 65536
        load = (32'(c.seconds) + 32'd1) * 32'd100;
        count_cs = load[15:0];
        running = 1'b1;
        expired = 1'b0;
      end
      MODE_PAUSE: running = ~c.paused;
      default: begin
        count_cs = '0;
        running = 1'b0;
        expired = 1'b1;
      end
    endcase
    r.segments     = seg_latch;
    r.digit_select = sel;
    r.expired      = expired;
    r.remaining    = count_cs;
    return r;
  endfunction

  function void note_command(cmd_t c);
    pending_displays.push_back(predict_display(c));
  endfunction

  function void compare_field(string name, int unsigned e, int unsigned a);
    if (e != a) begin
      $display("%t %s mismatch: expected %0d, actual %0d", $time, name, e, a);
      errors++;
    end
  endfunction

  function void check_display(disp_t got);
    disp_t want;
    if (pending_displays.size() == 0) begin
      $display("%t unexpected display transaction: expected none, actual %h", $time, got);
      errors++;
      return;
    end
    want = pending_displays.pop_front();
    compare_field("segments", want.segments, got.segments);
    compare_field("digit_select", want.digit_select, got.digit_select);
    compare_field("expired", want.expired, got.expired);
    compare_field("remaining", want.remaining, got.remaining);
  endfunction

  function int pending();
    return pending_displays.size();
  endfunction
endclass

module tb;
  localparam int CYCLE_LIMIT = 400000;
  localparam int RANDOM_ITEMS = 1400;

  logic  clk = 1'b0;
  logic  rst = 1'b1;
  logic  cmd_valid = 1'b0;
  logic  cmd_stall;
  cmd_t  cmd = '0;
  logic  disp_valid;
  logic  disp_stall = 1'b0;
  disp_t disp;

  timer_scoreboard sb;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int items_sent = 0;
  int item_goal = 0;
  int cycles = 0;

  countdown_timer_seven_seg dut (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .cmd       (cmd),
    .disp_valid(disp_valid),
    .disp_stall(disp_stall),
    .disp      (disp)
  );

  // 12 ns clock
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // run guard, counts every cycle from time zero
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // receiver back-pressure, one decision per edge
  always @(posedge clk) begin
    disp_stall <= !rst && ($urandom_range(99) < recv_idle_pct);
  end

  // both handshakes are sampled at the edge with their pre-edge values;
  // a command transaction is noted before any result of the same edge is checked
  always @(posedge clk) begin
    if (!rst) begin
      if (cmd_valid && !cmd_stall) sb.note_command(cmd);
      if (disp_valid && !disp_stall) sb.check_display(disp);
    end
  end

  function automatic cmd_t make_cmd(logic [1:0] m, logic [9:0] s, logic p);
    cmd_t c;
    c.mode    = m;
    c.seconds = s;
    c.paused  = p;
    return c;
  endfunction

  // offer one command transaction, with random idle cycles ahead of it,
  // and hold it until the block takes it
  task automatic send_command(cmd_t c);
    while ($urandom_range(99) < send_idle_pct) begin
      cmd_valid <= 1'b0;
      @(posedge clk);
    end
    cmd_valid <= 1'b1;
    cmd       <= c;
    @(posedge clk);
    while (cmd_stall) @(posedge clk);
    items_sent++;
  endtask

  task automatic send_tick();
    send_command(make_cmd(MODE_TICK, 10'($urandom_range(1023)), 1'($urandom_range(1))));
  endtask

  // start, then mostly ticks with an occasional pause and resume;
  // short loads are often run all the way down to expiry
  task automatic run_countdown();
    logic [9:0] secs;
    int         r;
    int         ticks;
    r = $urandom_range(99);
    if (r < 60) secs = 10'd0;
    else if (r < 85) secs = 10'($urandom_range(1, 3));
    else secs = 10'($urandom_range(1023));
    send_command(make_cmd(MODE_START, secs, 1'($urandom_range(1))));
    if (secs <= 10'd3 && $urandom_range(1) == 1)
      ticks = (int'(secs) + 1) * 100 + $urandom_range(4);
    else
      ticks = $urandom_range(1, 40);
    // the tick run ends early once the phase has sent its share
    for (int i = 0; i < ticks && items_sent < item_goal; i++) begin
      if ($urandom_range(99) < 3) begin
        send_command(make_cmd(MODE_PAUSE, 10'($urandom_range(1023)), 1'b1));
        repeat ($urandom_range(3)) send_tick();
        send_command(make_cmd(MODE_PAUSE, 10'($urandom_range(1023)), 1'b0));
      end
      send_tick();
    end
    if ($urandom_range(3) == 0) send_command(make_cmd(MODE_STOP, '0, 1'b0));
  endtask

  // noise: any mode with any field values, out-of-order pause and resume
  task automatic send_noise();
    repeat ($urandom_range(1, 8))
      send_command(make_cmd(2'($urandom_range(3)), 10'($urandom_range(1023)),
                            1'($urandom_range(1))));
  endtask

  task automatic drain_results();
    cmd_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  initial begin
    sb = new();
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    send_idle_pct = 13;
    recv_idle_pct = 48;

    // directed part
    send_command(make_cmd(MODE_TICK, '0, 1'b0));     // idle tick, select zero shows '0.'
    send_command(make_cmd(MODE_TICK, '1, 1'b1));     // idle tick, select one
    send_command(make_cmd(MODE_START, 10'd654, 1'b0)); // largest in-range load
    send_command(make_cmd(MODE_TICK, '0, 1'b0));     // thousands digit
    send_command(make_cmd(MODE_TICK, '0, 1'b0));     // hundreds digit
    send_command(make_cmd(MODE_PAUSE, '0, 1'b1));
    send_command(make_cmd(MODE_TICK, '0, 1'b0));     // paused, no decrement
    send_command(make_cmd(MODE_PAUSE, '1, 1'b0));
    send_command(make_cmd(MODE_TICK, '0, 1'b0));
    send_command(make_cmd(MODE_START, 10'd1023, 1'b1)); // load wraps modulo 65536
    send_command(make_cmd(MODE_TICK, '0, 1'b0));
    send_command(make_cmd(MODE_START, 10'd8, 1'b0));  // 900, below one thousand
    send_command(make_cmd(MODE_TICK, '0, 1'b0));
    send_command(make_cmd(MODE_TICK, '0, 1'b0));
    send_command(make_cmd(MODE_STOP, '1, 1'b1));
    send_command(make_cmd(MODE_PAUSE, '0, 1'b0));     // resume at zero while expired
    send_command(make_cmd(MODE_TICK, '0, 1'b0));     // wraps to 65535, expired stays set
    send_command(make_cmd(MODE_TICK, '0, 1'b0));
    send_command(make_cmd(MODE_STOP, '0, 1'b0));
    send_command(make_cmd(MODE_START, 10'd0, 1'b0));  // smallest load
    send_command(make_cmd(MODE_TICK, '0, 1'b0));     // below one hundred
    send_command(make_cmd(MODE_TICK, '0, 1'b0));
    send_command(make_cmd(MODE_START, 10'd655, 1'b0)); // just above range, wraps to 64
    send_command(make_cmd(MODE_TICK, '0, 1'b0));
    send_command(make_cmd(MODE_TICK, '0, 1'b0));

    // random part in three idling phases, each ending with a full drain
    item_goal = items_sent;
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 13;
          recv_idle_pct = 48;
        end
        1: begin
          send_idle_pct = 48;
          recv_idle_pct = 13;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      item_goal += RANDOM_ITEMS / 3;
      while (items_sent < item_goal) begin
        if ($urandom_range(9) < 7) run_countdown();
        else send_noise();
      end
      drain_results();
    end

    repeat (8) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule

### filelist.f
sv/cdt_pkg.sv
sv/cdt_display.sv
sv/cdt_ctrl.sv
sv/countdown_timer_seven_seg.sv
test/tb.sv
